@@ sv/camera_follow_dead_zone_clamp_assert.svh @@
// Assertion macros for the camera follow block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef CAMERA_FOLLOW_DEAD_ZONE_CLAMP_ASSERT_SVH
`define CAMERA_FOLLOW_DEAD_ZONE_CLAMP_ASSERT_SVH

// same-cycle implication
`define CFDZ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CFDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/cfdz_pkg.sv @@
// Package for the camera follow block: opcodes, register indexes,
// coordinate limits and the structs passed between config and axis lanes.
package cfdz_pkg;

	localparam int CoordW = 24;
	localparam int GainW  = 17;

	localparam logic signed [CoordW-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [CoordW-1:0] COORD_MIN = 24'sh800000;
	localparam logic [GainW-1:0]         GAIN_ONE  = 17'd65536;
	localparam logic [GainW-1:0]         GAIN_RST  = 17'd8192;

	typedef enum logic {
		OP_FOLLOW = 1'b0,
		OP_SET    = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_BOUNDS_ENABLE  = 3'd0,
		REG_BOUNDS_LEFT    = 3'd1,
		REG_BOUNDS_TOP     = 3'd2,
		REG_BOUNDS_WIDTH   = 3'd3,
		REG_BOUNDS_HEIGHT  = 3'd4,
		REG_VIEW_EXTENT    = 3'd5,
		REG_DEAD_ZONE_HALF = 3'd6,
		REG_FOLLOW_GAIN    = 3'd7
	} reg_idx_t;

	// per-axis view of the configuration
	typedef struct packed {
		logic signed [23:0] edge_pos;  // world left or top
		logic [22:0]        size;      // world width or height
		logic [23:0]        view;      // view width or height
		logic [23:0]        half;      // dead-zone half extent
	} axis_cfg_t;

	// controls shared by both lanes
	typedef struct packed {
		logic              load;
		op_t               op;
		logic              target_valid;
		logic              bounds_en;
		logic [GainW-1:0]  gain;       // already limited to one
	} lane_ctrl_t;

endpackage

@@ sv/cfdz_item_if.sv @@
// Request channel of the camera follow block: opcode and position.
// Depends on cfdz_pkg.
interface cfdz_item_if;
	logic               valid;
	logic               ready;
	cfdz_pkg::op_t      op;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic               target_valid;

	modport source (output valid, op, pos_x, pos_y, target_valid, input ready);
	modport sink   (input valid, op, pos_x, pos_y, target_valid, output ready);
endinterface

@@ sv/cfdz_result_if.sv @@
// Result channel of the camera follow block: view centre after each request.
// No package dependency.
interface cfdz_result_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] centre_x;
	logic signed [23:0] centre_y;

	modport source (output valid, centre_x, centre_y, input ready);
	modport sink   (input valid, centre_x, centre_y, output ready);
endinterface

@@ sv/cfdz_cfg.sv @@
// Configuration register file of the camera follow block.
// Splits the registers into per-axis structs; depends on cfdz_pkg.
module cfdz_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        we,
	input  logic [2:0]                  idx,
	input  logic [47:0]                 data,
	output cfdz_pkg::axis_cfg_t         ax_x,
	output cfdz_pkg::axis_cfg_t         ax_y,
	output logic                        bounds_en,
	output logic [cfdz_pkg::GainW-1:0]  gain
);

	logic               bounds_en_q;
	logic signed [23:0] left_q;
	logic signed [23:0] top_q;
	logic [22:0]        width_q;
	logic [22:0]        height_q;
	logic [47:0]        extent_q;
	logic [47:0]        dz_half_q;
	logic [16:0]        gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_en_q <= 1'b0;
			left_q      <= '0;
			top_q       <= '0;
			width_q     <= '0;
			height_q    <= '0;
			extent_q    <= '0;
			dz_half_q   <= '0;
			gain_q      <= cfdz_pkg::GAIN_RST;
		end else if (we) begin
			case (cfdz_pkg::reg_idx_t'(idx))
				cfdz_pkg::REG_BOUNDS_ENABLE:  bounds_en_q <= data[0];
				cfdz_pkg::REG_BOUNDS_LEFT:    left_q      <= signed'(data[23:0]);
				cfdz_pkg::REG_BOUNDS_TOP:     top_q       <= signed'(data[23:0]);
				cfdz_pkg::REG_BOUNDS_WIDTH:   width_q     <= data[22:0];
				cfdz_pkg::REG_BOUNDS_HEIGHT:  height_q    <= data[22:0];
				cfdz_pkg::REG_VIEW_EXTENT:    extent_q    <= data;
				cfdz_pkg::REG_DEAD_ZONE_HALF: dz_half_q   <= data;
				cfdz_pkg::REG_FOLLOW_GAIN:    gain_q      <= data[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ax_x.edge_pos = left_q;
		ax_x.size     = width_q;
		ax_x.view     = extent_q[23:0];
		ax_x.half     = dz_half_q[23:0];
		ax_y.edge_pos = top_q;
		ax_y.size     = height_q;
		ax_y.view     = extent_q[47:24];
		ax_y.half     = dz_half_q[47:24];
	end

	assign bounds_en = bounds_en_q;
	// gains above one behave as one
	assign gain = (gain_q > cfdz_pkg::GAIN_ONE) ? cfdz_pkg::GAIN_ONE : gain_q;

endmodule

@@ sv/cfdz_axis.sv @@
// One axis lane of the camera follow block: dead zone, gain approach,
// world clamp and the centre register for that axis. Depends on cfdz_pkg.
module cfdz_axis (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfdz_pkg::axis_cfg_t        cfg,
	input  cfdz_pkg::lane_ctrl_t       ctrl,
	input  logic signed [23:0]         pos,
	output logic signed [23:0]         centre
);

	logic signed [23:0] centre_q;
	logic signed [25:0] cur_w;
	logic signed [25:0] tgt_w;
	logic signed [25:0] half_w;
	logic signed [25:0] want;
	logic signed [26:0] diff;
	logic signed [17:0] gain_s;
	logic signed [44:0] prod;
	logic signed [44:0] prod_r;
	logic signed [28:0] step;
	logic signed [28:0] moved;
	logic signed [28:0] pre;
	logic signed [25:0] lo;
	logic signed [25:0] hi;
	logic signed [25:0] mid;
	logic               narrow;
	logic signed [28:0] clamped;
	logic signed [23:0] sat;
	logic signed [23:0] nxt;

	// dead zone: move only far enough to put the target on the zone edge
	always_comb begin
		cur_w  = 26'(centre_q);
		tgt_w  = 26'(pos);
		half_w = signed'({2'b00, cfg.half});
		if (tgt_w < cur_w - half_w)
			want = tgt_w + half_w;
		else if (tgt_w > cur_w + half_w)
			want = tgt_w - half_w;
		else
			want = cur_w;
	end

	// approach: product rounded to nearest, ties toward plus infinity
	always_comb begin
		diff   = 27'(want) - 27'(cur_w);
		gain_s = signed'({1'b0, ctrl.gain});
		prod   = 45'(diff) * 45'(gain_s);
		prod_r = prod + 45'sd32768;
		step   = prod_r[44:16];
		moved  = 29'(cur_w) + step;
		pre    = (ctrl.op == cfdz_pkg::OP_SET) ? 29'(pos) : moved;
	end

	// world clamp; a world no wider than the view centres on the world
	always_comb begin
		narrow = ({1'b0, cfg.size} <= cfg.view);
		mid    = 26'(cfg.edge_pos) + signed'({4'b0000, cfg.size[22:1]});
		lo     = 26'(cfg.edge_pos) + signed'({3'b000, cfg.view[23:1]});
		hi     = 26'(cfg.edge_pos) + signed'({3'b000, cfg.size})
			- signed'({3'b000, cfg.view[23:1]});
		if (!ctrl.bounds_en)
			clamped = pre;
		else if (narrow)
			clamped = 29'(mid);
		else if (pre < 29'(lo))
			clamped = 29'(lo);
		else if (pre > 29'(hi))
			clamped = 29'(hi);
		else
			clamped = pre;

		if (clamped > 29'(cfdz_pkg::COORD_MAX))
			sat = cfdz_pkg::COORD_MAX;
		else if (clamped < 29'(cfdz_pkg::COORD_MIN))
			sat = cfdz_pkg::COORD_MIN;
		else
			sat = clamped[23:0];

		if (ctrl.op == cfdz_pkg::OP_FOLLOW && !ctrl.target_valid)
			nxt = centre_q;
		else
			nxt = sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= '0;
		end else if (ctrl.load) begin
			centre_q <= nxt;
		end
	end

	assign centre = centre_q;

endmodule

@@ sv/camera_follow_dead_zone_clamp.sv @@
// Camera follow with dead zone, fixed-gain approach and world clamp.
// Returns the updated view centre in the cycle after a request is accepted;
// the x and y lanes run side by side, each keeping its centre in a register
// closing a loop (dead-zone compare, one 27x18 multiply, clamp) that sets the
// rate of one request per clock while the result side does not stall. A new
// request is taken while the previous result is being taken, so back-to-back
// traffic sees no bubbles. Coordinates are signed Q16.8, the gain Q1.16. The
// user must write configuration only while no request is in flight; the block
// does not enforce it. No clearing pass after reset. Depends on cfdz_pkg,
// cfdz_item_if, cfdz_result_if, cfdz_cfg, cfdz_axis and the assertion macros.
`include "camera_follow_dead_zone_clamp_assert.svh"

module camera_follow_dead_zone_clamp (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [47:0]   cfg_data,
	cfdz_item_if.sink     in_ch,
	cfdz_result_if.source out_ch
);

	cfdz_pkg::axis_cfg_t        ax_x;
	cfdz_pkg::axis_cfg_t        ax_y;
	logic                       bounds_en;
	logic [cfdz_pkg::GainW-1:0] gain;
	cfdz_pkg::lane_ctrl_t       ctrl;
	logic                       fire;
	logic                       out_valid_q;
	logic signed [23:0]         cx;
	logic signed [23:0]         cy;

	cfdz_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.we        (cfg_we),
		.idx       (cfg_index),
		.data      (cfg_data),
		.ax_x      (ax_x),
		.ax_y      (ax_y),
		.bounds_en (bounds_en),
		.gain      (gain)
	);

	// output register frees up in the same cycle it is taken
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign fire        = in_ch.valid && in_ch.ready;

	always_comb begin
		ctrl.load         = fire;
		ctrl.op           = in_ch.op;
		ctrl.target_valid = in_ch.target_valid;
		ctrl.bounds_en    = bounds_en;
		ctrl.gain         = gain;
	end

	cfdz_axis u_lane_x (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (ax_x),
		.ctrl   (ctrl),
		.pos    (in_ch.pos_x),
		.centre (cx)
	);

	cfdz_axis u_lane_y (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (ax_y),
		.ctrl   (ctrl),
		.pos    (in_ch.pos_y),
		.centre (cy)
	);

	// merge: both lane registers form the result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.centre_x = cx;
	assign out_ch.centre_y = cy;

	`CFDZ_ASSERT_NEXT(a_result_follows, fire, out_ch.valid, "no result after request")
	`CFDZ_ASSERT_NOW(a_stall_blocks, out_ch.valid && !out_ch.ready, !in_ch.ready, "request taken while result stalled")
	`CFDZ_ASSERT_NEXT(a_no_target_hold, fire && in_ch.op == cfdz_pkg::OP_FOLLOW && !in_ch.target_valid, $stable(cx) && $stable(cy), "centre moved without target")

endmodule

@@ tb/cfdz_follow_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the camera follow block: tracks the register writes, predicts
// the view centre for each accepted request and checks the result channel.
// Depends on cfdz_pkg, cfdz_item_if and cfdz_result_if.
module cfdz_follow_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	cfdz_item_if        req_ch,
	cfdz_result_if      res_ch,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
	} centre_t;

	logic               bounds_en;
	logic signed [23:0] left_edge;
	logic signed [23:0] top_edge;
	logic [22:0]        world_w;
	logic [22:0]        world_h;
	logic [47:0]        view_ext;
	logic [47:0]        dz_half;
	logic [16:0]        gain;
	centre_t            centre;
	centre_t            centre_q[$];

	function automatic longint sat_coord(longint v);
		if (v > longint'(cfdz_pkg::COORD_MAX))
			return longint'(cfdz_pkg::COORD_MAX);
		if (v < longint'(cfdz_pkg::COORD_MIN))
			return longint'(cfdz_pkg::COORD_MIN);
		return v;
	endfunction

	function automatic longint clamp_world(longint v, longint edge_pos, longint size,
			longint view);
		longint lo, hi;
		if (!bounds_en)
			return sat_coord(v);
		// world no wider than the view: sit on the world middle
		if (size <= view)
			return sat_coord(edge_pos + (size >>> 1));
		lo = edge_pos + (view >>> 1);
		hi = edge_pos + size - (view >>> 1);
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return sat_coord(v);
	endfunction

	function automatic longint approach_axis(longint cur, longint tgt, longint half,
			longint g);
		longint want;
		if (tgt < cur - half)
			want = tgt + half;
		else if (tgt > cur + half)
			want = tgt - half;
		else
			want = cur;
		// round half up, arithmetic shift gives the floor
		return cur + (((want - cur) * g + 32768) >>> 16);
	endfunction

	function automatic centre_t next_centre(cfdz_pkg::op_t op, logic signed [23:0] px,
			logic signed [23:0] py, logic tv);
		centre_t nxt;
		longint g;
		nxt = centre;
		g = (gain > cfdz_pkg::GAIN_ONE) ? longint'(cfdz_pkg::GAIN_ONE) : longint'(gain);
		if (op == cfdz_pkg::OP_SET) begin
			nxt.x = 24'(clamp_world(longint'(px), longint'(left_edge), longint'(world_w),
				longint'(view_ext[23:0])));
			nxt.y = 24'(clamp_world(longint'(py), longint'(top_edge), longint'(world_h),
				longint'(view_ext[47:24])));
		end else if (tv) begin
			nxt.x = 24'(clamp_world(approach_axis(longint'(centre.x), longint'(px),
				longint'(dz_half[23:0]), g), longint'(left_edge), longint'(world_w),
				longint'(view_ext[23:0])));
			nxt.y = 24'(clamp_world(approach_axis(longint'(centre.y), longint'(py),
				longint'(dz_half[47:24]), g), longint'(top_edge), longint'(world_h),
				longint'(view_ext[47:24])));
		end
		return nxt;
	endfunction

	always @(posedge clk) begin
		centre_t got, want;
		if (!arst_n) begin
			bounds_en = 1'b0;
			left_edge = '0;
			top_edge  = '0;
			world_w   = '0;
			world_h   = '0;
			view_ext  = '0;
			dz_half   = '0;
			gain      = cfdz_pkg::GAIN_RST;
			centre    = '0;
			centre_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfdz_pkg::reg_idx_t'(cfg_index))
					cfdz_pkg::REG_BOUNDS_ENABLE:  bounds_en = cfg_data[0];
					cfdz_pkg::REG_BOUNDS_LEFT:    left_edge = cfg_data[23:0];
					cfdz_pkg::REG_BOUNDS_TOP:     top_edge  = cfg_data[23:0];
					cfdz_pkg::REG_BOUNDS_WIDTH:   world_w   = cfg_data[22:0];
					cfdz_pkg::REG_BOUNDS_HEIGHT:  world_h   = cfg_data[22:0];
					cfdz_pkg::REG_VIEW_EXTENT:    view_ext  = cfg_data;
					cfdz_pkg::REG_DEAD_ZONE_HALF: dz_half   = cfg_data;
					cfdz_pkg::REG_FOLLOW_GAIN:    gain      = cfg_data[16:0];
					default: ;
				endcase
			end
			// result first: a request taken at this edge cannot answer at it
			if (res_ch.valid && res_ch.ready) begin
				got.x = res_ch.centre_x;
				got.y = res_ch.centre_y;
				if (centre_q.size() == 0) begin
					$error("result with no request outstanding: centre_x %0d centre_y %0d",
						got.x, got.y);
					errors++;
				end else begin
					want = centre_q.pop_front();
					if (got.x !== want.x) begin
						$error("centre_x mismatch: expected %0d, got %0d", want.x, got.x);
						errors++;
					end
					if (got.y !== want.y) begin
						$error("centre_y mismatch: expected %0d, got %0d", want.y, got.y);
						errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				centre = next_centre(req_ch.op, req_ch.pos_x, req_ch.pos_y,
					req_ch.target_valid);
				centre_q.push_back(centre);
			end
		end
		pending = centre_q.size();
	end

endmodule

@@ tb/tb_camera_follow_dead_zone_clamp.sv @@
`timescale 1ns / 1ps
// Top of the camera follow testbench: clock, reset, register programming,
// request and result traffic with random idling, and the verdict.
// Depends on cfdz_pkg, the channel interfaces, the block and cfdz_follow_checker.
module tb_camera_follow_dead_zone_clamp;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 250;
	localparam int HOLD_CYCLES    = 80;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	int          errors;
	int          pending;
	int          idle_cycles;
	int          hold_left;
	bit          calm;
	bit          hold_go;

	cfdz_item_if   item_ch ();
	cfdz_result_if result_ch ();

	camera_follow_dead_zone_clamp DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (item_ch),
		.out_ch    (result_ch)
	);

	cfdz_follow_checker follow_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_ch    (item_ch),
		.res_ch    (result_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// result side: random stalls, calm stretches, and one long hold-off
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= calm || ($urandom_range(99) >= 19);
			end
		end
	end

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 65535)) - 24'd32768;
			2: case ($urandom_range(3))
				0: return cfdz_pkg::COORD_MAX;
				1: return cfdz_pkg::COORD_MIN;
				2: return 24'd0;
				default: return 24'hFFFFFF;
			endcase
			default: return 24'($urandom_range(0, 2097151)) - 24'd1048576;
		endcase
	endfunction

	function automatic logic [23:0] rand_span();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 65535));
			2: return $urandom_range(1) ? 24'hFFFFFF : 24'd0;
			default: return 24'($urandom_range(0, 2097152));
		endcase
	endfunction

	function automatic logic [16:0] rand_gain();
		case ($urandom_range(4))
			0: case ($urandom_range(2))
				0: return 17'd0;
				1: return cfdz_pkg::GAIN_ONE;
				default: return 17'h1FFFF;
			endcase
			1: return 17'($urandom_range(0, 131071));
			default: return 17'($urandom_range(1, 65536));
		endcase
	endfunction

	task automatic send_req(cfdz_pkg::op_t op, logic [23:0] x, logic [23:0] y, logic tv);
		int gap;
		if (!calm && $urandom_range(99) < 19) begin
			item_ch.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.op           <= op;
		item_ch.pos_x        <= x;
		item_ch.pos_y        <= y;
		item_ch.target_valid <= tv;
		do
			@(posedge clk);
		while (!(item_ch.valid && item_ch.ready));
		@(negedge clk);
	endtask

	// drain all outstanding requests, then write every register
	task automatic program_regs(logic en, logic [23:0] left, logic [23:0] top,
			logic [23:0] w, logic [23:0] h, logic [47:0] view, logic [47:0] dz,
			logic [16:0] g);
		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= cfdz_pkg::REG_BOUNDS_ENABLE;  cfg_data <= 48'(en);    @(negedge clk);
		cfg_index <= cfdz_pkg::REG_BOUNDS_LEFT;    cfg_data <= 48'(left);  @(negedge clk);
		cfg_index <= cfdz_pkg::REG_BOUNDS_TOP;     cfg_data <= 48'(top);   @(negedge clk);
		cfg_index <= cfdz_pkg::REG_BOUNDS_WIDTH;   cfg_data <= 48'(w);     @(negedge clk);
		cfg_index <= cfdz_pkg::REG_BOUNDS_HEIGHT;  cfg_data <= 48'(h);     @(negedge clk);
		cfg_index <= cfdz_pkg::REG_VIEW_EXTENT;    cfg_data <= view;       @(negedge clk);
		cfg_index <= cfdz_pkg::REG_DEAD_ZONE_HALF; cfg_data <= dz;         @(negedge clk);
		cfg_index <= cfdz_pkg::REG_FOLLOW_GAIN;    cfg_data <= 48'(g);     @(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = cfdz_pkg::REG_BOUNDS_ENABLE;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = cfdz_pkg::OP_FOLLOW;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.target_valid = 1'b0;
		calm = 1'b0;
		hold_go = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: no bounds, no dead zone, gain 1/8
		send_req(cfdz_pkg::OP_FOLLOW, 24'd0, 24'd0, 1'b1);
		send_req(cfdz_pkg::OP_SET, cfdz_pkg::COORD_MAX, cfdz_pkg::COORD_MIN, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, cfdz_pkg::COORD_MIN, cfdz_pkg::COORD_MAX, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, 24'h123456, 24'hABCDEF, 1'b0);
		send_req(cfdz_pkg::OP_SET, 24'hFFFFFF, 24'd1, 1'b0);
		send_req(cfdz_pkg::OP_FOLLOW, 24'd1, 24'hFFFFFF, 1'b1);

		// wide world on x, narrow on y, dead zone, full gain
		program_regs(1'b1, -24'sh1000, 24'h2000, 24'h8000, 24'h100,
			{24'h200, 24'h1000}, {24'h80, 24'h40}, cfdz_pkg::GAIN_ONE);
		send_req(cfdz_pkg::OP_SET, cfdz_pkg::COORD_MIN, cfdz_pkg::COORD_MAX, 1'b1);
		send_req(cfdz_pkg::OP_SET, cfdz_pkg::COORD_MAX, 24'd0, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, 24'd0, 24'd0, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, -24'sh3000, 24'h2100, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, 24'h1000, 24'h1000, 1'b0);

		// gain above one, widest dead zone, bounds off
		program_regs(1'b0, cfdz_pkg::COORD_MAX, cfdz_pkg::COORD_MIN, 24'h7FFFFF, 24'd0,
			48'd0, 48'hFFFFFF_FFFFFF, 17'h1FFFF);
		send_req(cfdz_pkg::OP_FOLLOW, cfdz_pkg::COORD_MAX, cfdz_pkg::COORD_MIN, 1'b1);
		send_req(cfdz_pkg::OP_SET, 24'd0, 24'd0, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, cfdz_pkg::COORD_MIN, cfdz_pkg::COORD_MAX, 1'b1);

		// clamp window that runs past the coordinate range
		program_regs(1'b1, cfdz_pkg::COORD_MAX, cfdz_pkg::COORD_MIN, 24'h7FFFFF, 24'h7FFFFF,
			48'd0, 48'd0, 17'd1);
		send_req(cfdz_pkg::OP_SET, cfdz_pkg::COORD_MAX, cfdz_pkg::COORD_MAX, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, cfdz_pkg::COORD_MIN, cfdz_pkg::COORD_MIN, 1'b1);
		send_req(cfdz_pkg::OP_SET, cfdz_pkg::COORD_MIN, cfdz_pkg::COORD_MIN, 1'b0);

		// rounding ties at half gain
		program_regs(1'b0, 24'd0, 24'd0, 24'd0, 24'd0, 48'd0, 48'd0, 17'd32768);
		send_req(cfdz_pkg::OP_SET, 24'd0, 24'd0, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, 24'd1, 24'hFFFFFF, 1'b1);
		send_req(cfdz_pkg::OP_FOLLOW, 24'hFFFFFD, 24'd3, 1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_regs(1'b1, cfdz_pkg::COORD_MIN, cfdz_pkg::COORD_MIN,
					24'h7FFFFF, 24'h7FFFFF, 48'hFFFFFF_FFFFFF, 48'hFFFFFF_FFFFFF,
					17'h1FFFF);
				1: program_regs(1'b1, cfdz_pkg::COORD_MAX, cfdz_pkg::COORD_MAX,
					24'h7FFFFF, 24'h7FFFFF, 48'd0, 48'd0, 17'd0);
				default: program_regs(1'($urandom), rand_coord(), rand_coord(), rand_span(),
					rand_span(), {rand_span(), rand_span()},
					($urandom_range(3) == 0) ? 48'd0 : {rand_span(), rand_span()},
					rand_gain());
			endcase
			calm = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 2 && n == 50)
					hold_go = 1'b1;
				send_req(($urandom_range(3) == 0) ? cfdz_pkg::OP_SET : cfdz_pkg::OP_FOLLOW,
					rand_coord(), rand_coord(), $urandom_range(99) < 85);
			end
		end
		calm = 1'b0;

		item_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
